FILE: design/irfts_pkg.sv
// Shared types and constants for the infrared frame transmit sequencer.
package irfts_pkg;

    // Phase codes of the frame sequencer.
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_PRE  = 2'd1;
    localparam logic [1:0] PH_DATA = 2'd2;
    localparam logic [1:0] PH_EPI  = 2'd3;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_PRE_MARK  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRE_SPACE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DATA_BIT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EPI_SPACE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_EPI_MARK  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INTERFRAME = 3'd5;

    // Operation codes of an input item.
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    // Reset values of the timing registers.
    localparam logic [15:0] RST_PRE_MARK   = 16'd750;
    localparam logic [15:0] RST_PRE_SPACE  = 16'd350;
    localparam logic [15:0] RST_DATA_BIT   = 16'd500;
    localparam logic [15:0] RST_EPI_SPACE  = 16'd350;
    localparam logic [15:0] RST_EPI_MARK   = 16'd750;
    localparam logic [15:0] RST_INTERFRAME = 16'd1000;

    // Width of the lit channel index on the result.
    localparam int unsigned IDX_W = 3;

    typedef struct packed {
        logic       operation;
        logic [7:0] beamer_id;
        logic [7:0] angle_code;
    } t_in_item;

    typedef struct packed {
        logic             accepted;
        logic             carrier_on;
        logic             period_load;
        logic [15:0]      period_value;
        logic             channel_on;
        logic [IDX_W-1:0] channel_index;
        logic             busy_res;
    } t_out_item;

    // Timing registers as seen by the step logic.
    typedef struct packed {
        logic [15:0] preamble_mark_len;
        logic [15:0] preamble_space_len;
        logic [15:0] data_bit_len;
        logic [15:0] epilogue_space_len;
        logic [15:0] epilogue_mark_len;
        logic [15:0] interframe_len;
    } t_cfg;

    // Frame progress state, apart from the channel pointer.
    typedef struct packed {
        logic [1:0] phase;
        logic [1:0] substage;
        logic [1:0] word_select;
        logic [3:0] bit_position;
        logic [7:0] id_byte;
        logic [7:0] angle_byte;
    } t_seq_state;

endpackage

FILE: design/irfts_cfg_regs.sv
// Timing register file of the infrared frame transmit sequencer.
module irfts_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [irfts_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]                     i_cfg_data,
    output irfts_pkg::t_cfg                 o_cfg
);

    irfts_pkg::t_cfg r_cfg;

    // Register writes; an index beyond the list is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.preamble_mark_len  <= irfts_pkg::RST_PRE_MARK;
            r_cfg.preamble_space_len <= irfts_pkg::RST_PRE_SPACE;
            r_cfg.data_bit_len       <= irfts_pkg::RST_DATA_BIT;
            r_cfg.epilogue_space_len <= irfts_pkg::RST_EPI_SPACE;
            r_cfg.epilogue_mark_len  <= irfts_pkg::RST_EPI_MARK;
            r_cfg.interframe_len     <= irfts_pkg::RST_INTERFRAME;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                irfts_pkg::REG_PRE_MARK:   r_cfg.preamble_mark_len  <= i_cfg_data;
                irfts_pkg::REG_PRE_SPACE:  r_cfg.preamble_space_len <= i_cfg_data;
                irfts_pkg::REG_DATA_BIT:   r_cfg.data_bit_len       <= i_cfg_data;
                irfts_pkg::REG_EPI_SPACE:  r_cfg.epilogue_space_len <= i_cfg_data;
                irfts_pkg::REG_EPI_MARK:   r_cfg.epilogue_mark_len  <= i_cfg_data;
                irfts_pkg::REG_INTERFRAME: r_cfg.interframe_len     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: design/irfts_step.sv
// Combinational step logic: next frame state and the result for one item.
module irfts_step #(
    parameter int unsigned CHANNELS = 8
) (
    input  irfts_pkg::t_seq_state i_state,
    input  logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] i_ptr,
    input  irfts_pkg::t_in_item   i_item,
    input  irfts_pkg::t_cfg       i_cfg,
    output irfts_pkg::t_seq_state o_next,
    output logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] o_ptr,
    output irfts_pkg::t_out_item  o_res
);

    localparam int unsigned PTR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic [7:0]                        data_byte;
    logic                              word_ok;
    logic [2:0]                        bit_sel;
    logic [PTR_W:0]                    ptr_inc;
    logic [PTR_W-1:0]                  ptr_wrap;
    logic [PTR_W+irfts_pkg::IDX_W-1:0] ptr_ext;

    // Byte on air for the current word, and the pointer advance.
    always_comb begin
        word_ok = 1'b1;
        case (i_state.word_select)
            2'd0:    data_byte = i_state.id_byte;
            2'd1:    data_byte = i_state.angle_byte;
            2'd2:    data_byte = ~i_state.angle_byte;
            default: begin
                data_byte = 8'd0;
                word_ok   = 1'b0;
            end
        endcase
        bit_sel  = 3'd7 - i_state.bit_position[2:0];
        ptr_inc  = {1'b0, i_ptr} + (PTR_W+1)'(1);
        ptr_wrap = (ptr_inc >= (PTR_W+1)'(CHANNELS)) ? '0 : ptr_inc[PTR_W-1:0];
        ptr_ext  = {{irfts_pkg::IDX_W{1'b0}}, i_ptr};
    end

    // Frame sequencing for one item.
    always_comb begin
        o_next = i_state;
        o_ptr  = i_ptr;
        o_res  = '0;

        if (i_item.operation == irfts_pkg::OP_START) begin
            if (i_state.phase == irfts_pkg::PH_IDLE) begin
                o_next.id_byte      = i_item.beamer_id;
                o_next.angle_byte   = i_item.angle_code;
                o_next.phase        = irfts_pkg::PH_PRE;
                o_next.substage     = 2'd0;
                o_next.word_select  = 2'd0;
                o_next.bit_position = 4'd0;
                o_res.accepted      = 1'b1;
            end
        end else begin
            unique case (i_state.phase)
                irfts_pkg::PH_DATA: begin
                    if (!word_ok) begin
                        // Unused word select: close the frame.
                        o_ptr               = '0;
                        o_next.phase        = irfts_pkg::PH_IDLE;
                        o_next.substage     = 2'd0;
                        o_next.word_select  = 2'd0;
                        o_next.bit_position = 4'd0;
                        o_res.period_load   = 1'b1;
                        o_res.period_value  = i_cfg.interframe_len;
                    end else begin
                        o_res.carrier_on    = data_byte[bit_sel];
                        o_res.period_load   = 1'b1;
                        o_res.period_value  = i_cfg.data_bit_len;
                        o_res.channel_on    = 1'b1;
                        o_res.channel_index = ptr_ext[irfts_pkg::IDX_W-1:0];
                        o_ptr               = ptr_wrap;
                        if (i_state.bit_position >= 4'd7) begin
                            o_next.bit_position = 4'd0;
                            if (i_state.word_select >= 2'd2) begin
                                o_next.phase       = irfts_pkg::PH_EPI;
                                o_next.substage    = 2'd0;
                                o_next.word_select = 2'd0;
                            end else begin
                                o_next.word_select = i_state.word_select + 2'd1;
                            end
                        end else begin
                            o_next.bit_position = i_state.bit_position + 4'd1;
                        end
                    end
                end
                irfts_pkg::PH_PRE: begin
                    o_ptr             = '0;
                    o_res.period_load = 1'b1;
                    case (i_state.substage)
                        2'd0: begin
                            o_res.carrier_on   = 1'b1;
                            o_res.period_value = i_cfg.preamble_mark_len;
                            o_next.substage    = 2'd1;
                        end
                        2'd1: begin
                            o_res.period_value = i_cfg.preamble_space_len;
                            o_next.substage    = 2'd2;
                        end
                        2'd2: begin
                            o_res.carrier_on   = 1'b1;
                            o_res.period_value = i_cfg.preamble_mark_len;
                            o_next.substage    = 2'd3;
                        end
                        default: begin
                            o_res.period_value  = i_cfg.preamble_space_len;
                            o_next.phase        = irfts_pkg::PH_DATA;
                            o_next.substage     = 2'd0;
                            o_next.word_select  = 2'd0;
                            o_next.bit_position = 4'd0;
                        end
                    endcase
                end
                irfts_pkg::PH_EPI: begin
                    o_ptr             = '0;
                    o_res.period_load = 1'b1;
                    case (i_state.substage)
                        2'd0: begin
                            o_res.period_value = i_cfg.epilogue_space_len;
                            o_next.substage    = 2'd1;
                        end
                        2'd1: begin
                            o_res.carrier_on   = 1'b1;
                            o_res.period_value = i_cfg.epilogue_mark_len;
                            o_next.substage    = 2'd2;
                        end
                        default: begin
                            // Final step, and the unused substage: back to idle.
                            o_res.period_value  = i_cfg.interframe_len;
                            o_next.phase        = irfts_pkg::PH_IDLE;
                            o_next.substage     = 2'd0;
                            o_next.word_select  = 2'd0;
                            o_next.bit_position = 4'd0;
                        end
                    endcase
                end
                default: begin
                    // A tick while idle changes nothing.
                end
            endcase
        end

        o_res.busy_res = (o_next.phase != irfts_pkg::PH_IDLE);
    end

endmodule

FILE: design/ir_frame_transmit_sequencer_core.sv
// Top level of the infrared frame transmit sequencer.
// Each accepted item (a timer tick or a start request) gives exactly one registered result
// item, and a new item can be taken on every clock: the frame state is updated in a
// single pass of combinational logic and the result lands in one output register. While that
// register holds a result the downstream side has stalled, o_in_stall is raised; otherwise the
// block takes an item on every cycle. Timing registers are written through the cfg port; the
// user must write them while no frame is in progress, as the block does not enforce this.
module ir_frame_transmit_sequencer_core #(
    parameter int unsigned CHANNELS = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  irfts_pkg::t_in_item             i_in_item,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output irfts_pkg::t_out_item            o_out_item,
    input  logic                            i_cfg_we,
    input  logic [irfts_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]                     i_cfg_data
);

    localparam int unsigned PTR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    irfts_pkg::t_cfg       cfg;
    irfts_pkg::t_seq_state r_state;
    irfts_pkg::t_seq_state n_state;
    logic [PTR_W-1:0]      r_ptr;
    logic [PTR_W-1:0]      n_ptr;
    irfts_pkg::t_out_item  n_out_item;
    irfts_pkg::t_out_item  r_out_item;
    logic                  r_out_valid;
    logic                  in_fire;

    irfts_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    irfts_step #(
        .CHANNELS (CHANNELS)
    ) u_step (
        .i_state (r_state),
        .i_ptr   (r_ptr),
        .i_item  (i_in_item),
        .i_cfg   (cfg),
        .o_next  (n_state),
        .o_ptr   (n_ptr),
        .o_res   (n_out_item)
    );

    // Input is held off only while a result waits on a stalled output.
    assign o_in_stall = r_out_valid & i_out_stall;
    assign in_fire    = i_in_valid & ~o_in_stall;

    // Frame state advances once per accepted item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
            r_ptr   <= '0;
        end else if (in_fire) begin
            r_state <= n_state;
            r_ptr   <= n_ptr;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule
